// ----- src/ilir_pkg.sv -----
// shared types and codes for the positional insert/remove list
// no dependencies

package ilir_pkg;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_WR,
    S_RM_FIRST,
    S_RM_WR,
    S_RM_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [31:0] removed_value;
    status_t            status;
    logic [4:0]         entry_count;
  } res_t;

endpackage

// ----- src/ilir_ram.sv -----
// generic single write port ram with registered read
// no dependencies

module ilir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/ilir_step.sv -----
// shared index unit: steps the cell index up or down and checks for the stop index
// no dependencies

module ilir_step #(
  parameter int AW = 4
) (
  input  logic [AW-1:0] idx,
  input  logic          down,
  input  logic [AW-1:0] target,
  output logic [AW-1:0] nxt,
  output logic          hit
);

  assign nxt = down ? idx - AW'(1) : idx + AW'(1);
  assign hit = (idx == target);

endmodule

// ----- src/ilir_ctrl.sv -----
// sequencer for the list: decodes a transaction, moves cells one at a time
// depends on ilir_pkg, ilir_ram, ilir_step

module ilir_ctrl
  import ilir_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [4:0]         position,
  input  logic signed [31:0] value,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_t             state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [AW-1:0]      idx, idx_next;
  logic [AW-1:0]      target, target_next;
  logic signed [31:0] val, val_next;
  logic signed [31:0] taken, taken_next;
  status_t            status, status_next;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [31:0]        wdata;
  logic [AW-1:0]      raddr;
  logic [31:0]        rdata;

  logic [AW-1:0]      nxt;
  logic               hit;
  logic               down;

  logic [PW-1:0]      pos_x;
  logic [PW-1:0]      count_x;

  assign pos_x   = PW'(position);
  assign count_x = PW'(count);
  assign down    = (state == S_INS_CHK) || (state == S_INS_WR);

  ilir_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  ilir_step #(.AW(AW)) u_step (
    .idx    (idx),
    .down   (down),
    .target (target),
    .nxt    (nxt),
    .hit    (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    target <= target_next;
    val    <= val_next;
    taken  <= taken_next;
    status <= status_next;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    target_next = target;
    val_next    = val;
    taken_next  = taken;
    status_next = status;
    we          = 1'b0;
    waddr       = idx;
    wdata       = rdata;
    raddr       = nxt;
    in_ready    = 1'b0;
    res_valid   = 1'b0;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          val_next    = value;
          taken_next  = '0;
          status_next = ST_OK;
          if (mode == MODE_INSERT) begin
            if (count == '0) begin
              idx_next    = '0;
              target_next = '0;
              state_next  = S_INS_CHK;
            end else if (count == DEPTH_C) begin
              status_next = ST_FULL;
              state_next  = S_DONE;
            end else if (pos_x > count_x) begin
              status_next = ST_BADPOS;
              state_next  = S_DONE;
            end else begin
              idx_next    = count[AW-1:0];
              target_next = pos_x[AW-1:0];
              state_next  = S_INS_CHK;
            end
          end else begin
            if (count == '0) begin
              status_next = ST_EMPTY;
              state_next  = S_DONE;
            end else if (pos_x >= count_x) begin
              status_next = ST_BADPOS;
              state_next  = S_DONE;
            end else begin
              raddr       = pos_x[AW-1:0];
              idx_next    = pos_x[AW-1:0];
              count_next  = count - CW'(1);
              target_next = AW'(count - CW'(1));
              state_next  = S_RM_FIRST;
            end
          end
        end
      end
      S_INS_CHK: begin
        if (hit) begin
          we         = 1'b1;
          wdata      = val;
          count_next = count + CW'(1);
          state_next = S_DONE;
        end else begin
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        we         = 1'b1;
        idx_next   = nxt;
        state_next = S_INS_CHK;
      end
      S_RM_FIRST: begin
        taken_next = rdata;
        state_next = hit ? S_DONE : S_RM_WR;
      end
      S_RM_WR: begin
        we         = 1'b1;
        idx_next   = nxt;
        state_next = S_RM_CHK;
      end
      S_RM_CHK: begin
        state_next = hit ? S_DONE : S_RM_WR;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res.removed_value = taken;
  assign res.status        = status;
  assign res.entry_count   = count_x[4:0];

endmodule

// ----- src/indexed_list_insert_remove_top.sv -----
// top level of the positional insert/remove list: stream ports and result register
// depends on ilir_pkg, ilir_ctrl

// Keeps an ordered list of up to DEPTH signed 32-bit entries in a RAM with one
// write port and one registered read port. Each input transaction inserts a
// value at a position or removes the entry at a position, and yields one result
// with the removed value, a status code and the entry count afterwards. Cells
// are moved one at a time through the RAM, a read and then a write per moved
// cell. The number of cells moved is count - position on insert, count -
// position - 1 on remove, and none on an insert into an empty list. A rejected
// transaction goes straight to its result. The input is ready again in the
// cycle after the result is taken into the output register. The input is not
// ready while a transaction is in progress or while its finished result waits
// for room in the output register. A new transaction is accepted while an
// earlier result still waits in the output register. No clearing pass after reset.

module indexed_list_insert_remove_top
  import ilir_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // mode, position[4:0], value[31:0], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // removed_value[31:0], status[1:0], entry_count[4:0], zero pad
);

  logic res_valid;
  logic res_ready;
  res_t res;
  res_t out_res;

  ilir_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .mode      (s_tdata[0]),
    .position  (s_tdata[5:1]),
    .value     (s_tdata[37:6]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {1'b0, out_res.entry_count, out_res.status, out_res.removed_value};

endmodule
